@@ hdl/tfmb_pkg.sv @@
`timescale 1ns / 1ps

package tfmb_pkg;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Field widths
  localparam int SIZE_REG_W = 11;
  localparam int PIXEL_W    = 8;
  localparam int COUNT_W    = 19;
  localparam int BOX_W      = 10;

  // Width of the arithmetic in which the deviation gate wraps
  localparam int GATE_W = 64;

  localparam int MIN_SIZE = 16;

  // Register values after reset
  localparam int RST_FRAME_WIDTH    = 640;
  localparam int RST_FRAME_HEIGHT   = 480;
  localparam int RST_WINDOW_MARGIN  = 10;
  localparam int RST_BOX_PAD        = 10;
  localparam int RST_DIFF_THRESHOLD = 35;
  localparam int RST_MAX_DEVIATION  = 20;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_WINDOW_MARGIN,
    REG_BOX_PAD,
    REG_DIFF_THRESHOLD,
    REG_MAX_DEVIATION
  } reg_index_t;

  typedef struct packed {
    logic [7:0] window_margin;
    logic [7:0] box_pad;
    logic [7:0] diff_threshold;
    logic [7:0] max_deviation;
  } cfg_t;

  typedef struct packed {
    logic motion_bit;
    logic frame_done;
  } px_flags_t;

  typedef struct packed {
    logic               motion_bit;
    logic               frame_done;
    logic [COUNT_W-1:0] change_count;
    logic [BOX_W-1:0]   box_left;
    logic [BOX_W-1:0]   box_top;
    logic [BOX_W-1:0]   box_right;
    logic [BOX_W-1:0]   box_bottom;
    logic               motion_found;
  } result_t;

endpackage

@@ hdl/three_frame_motion_box.sv @@
`timescale 1ns / 1ps

// Three-frame difference motion detector. Co-located grey pixels of three
// successive frames enter in raster order, one item per clock, and every
// item gives one result via the input, erosion, gate and output registers:
// the eroded motion bit of that pixel and, on the last pixel of a frame,
// the sampled motion count and padded bounding box, gated by the frame's
// deviation. Throughput is one item per clock; a two-entry output buffer
// keeps the input side running while a result waits, and input ready falls
// only once both entries are full. After reset the line store of raw bits
// is filled with ones, one column a cycle; no item is taken until it is
// full, while register writes are taken as ever. The six registers lie at
// byte addresses 0 (frame width), 4 (frame height), 8 (window margin),
// 12 (box pad), 16 (difference threshold) and 20 (deviation limit); they
// must be written only while no item is in flight; the block does not check.
module three_frame_motion_box
  import tfmb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  frame_start,
  input  logic [PIXEL_W-1:0]    prev_pixel,
  input  logic [PIXEL_W-1:0]    current_pixel,
  input  logic [PIXEL_W-1:0]    next_pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  motion_bit,
  output logic                  frame_done,
  output logic [COUNT_W-1:0]    change_count,
  output logic [BOX_W-1:0]      box_left,
  output logic [BOX_W-1:0]      box_top,
  output logic [BOX_W-1:0]      box_right,
  output logic [BOX_W-1:0]      box_bottom,
  output logic                  motion_found
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int W_W = COL_W + 1;
  localparam int H_W = ROW_W + 1;
  localparam int PIX_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  logic [W_W-1:0]   frame_w;
  logic [H_W-1:0]   frame_h;
  cfg_t             cfg;
  logic             advance;
  logic             e_valid;
  px_flags_t        e_flags;
  logic [PIX_W-1:0] e_ones;
  logic [PIX_W-1:0] e_sampled;
  logic [W_W-1:0]   e_least_col;
  logic [COL_W-1:0] e_most_col;
  logic [H_W-1:0]   e_least_row;
  logic [ROW_W-1:0] e_most_row;
  logic             g_valid;
  result_t          g_result;
  logic             push;
  logic             load_out;
  logic             skid_valid;
  result_t          skid_data;
  result_t          out_data;

  assign pready = 1'b1;

  tfmb_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .frame_w (frame_w),
    .frame_h (frame_h),
    .cfg     (cfg)
  );

  tfmb_erode #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_erode (
    .clk           (clk),
    .rst           (rst),
    .frame_w       (frame_w),
    .frame_h       (frame_h),
    .cfg           (cfg),
    .advance       (advance),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .frame_start   (frame_start),
    .prev_pixel    (prev_pixel),
    .current_pixel (current_pixel),
    .next_pixel    (next_pixel),
    .e_valid       (e_valid),
    .e_flags       (e_flags),
    .e_ones        (e_ones),
    .e_sampled     (e_sampled),
    .e_least_col   (e_least_col),
    .e_most_col    (e_most_col),
    .e_least_row   (e_least_row),
    .e_most_row    (e_most_row)
  );

  tfmb_gate #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_gate (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .frame_w     (frame_w),
    .frame_h     (frame_h),
    .cfg         (cfg),
    .e_valid     (e_valid),
    .e_flags     (e_flags),
    .e_ones      (e_ones),
    .e_sampled   (e_sampled),
    .e_least_col (e_least_col),
    .e_most_col  (e_most_col),
    .e_least_row (e_least_row),
    .e_most_row  (e_most_row),
    .g_valid     (g_valid),
    .g_result    (g_result)
  );

  // The pipeline moves whenever the skid entry is free; an item leaving the
  // last stage lands in the output register or, if that is held, the skid.
  assign advance  = !skid_valid;
  assign push     = g_valid && advance;
  assign load_out = out_ready || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= skid_valid ? skid_data : g_result;
    end else if (push) begin
      skid_data <= g_result;
    end
  end

  assign motion_bit   = out_data.motion_bit;
  assign frame_done   = out_data.frame_done;
  assign change_count = out_data.change_count;
  assign box_left     = out_data.box_left;
  assign box_top      = out_data.box_top;
  assign box_right    = out_data.box_right;
  assign box_bottom   = out_data.box_bottom;
  assign motion_found = out_data.motion_found;

endmodule

@@ hdl/tfmb_cfg.sv @@
`timescale 1ns / 1ps

module tfmb_cfg
  import tfmb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int W_W = $clog2(MAX_WIDTH) + 1,
  localparam int H_W = $clog2(MAX_HEIGHT) + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic [W_W-1:0]        frame_w,
  output logic [H_W-1:0]        frame_h,
  output cfg_t                  cfg
);

  logic [SIZE_REG_W-1:0] frame_width;
  logic [SIZE_REG_W-1:0] frame_height;
  logic [7:0]            window_margin;
  logic [7:0]            box_pad;
  logic [7:0]            diff_threshold;
  logic [7:0]            max_deviation;
  logic                  wr_en;
  reg_index_t            reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_index_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= SIZE_REG_W'(RST_FRAME_WIDTH);
      frame_height   <= SIZE_REG_W'(RST_FRAME_HEIGHT);
      window_margin  <= 8'(RST_WINDOW_MARGIN);
      box_pad        <= 8'(RST_BOX_PAD);
      diff_threshold <= 8'(RST_DIFF_THRESHOLD);
      max_deviation  <= 8'(RST_MAX_DEVIATION);
    end else if (wr_en) begin
      case (reg_sel)
        REG_FRAME_WIDTH:    frame_width    <= pwdata[SIZE_REG_W-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= pwdata[SIZE_REG_W-1:0];
        REG_WINDOW_MARGIN:  window_margin  <= pwdata[7:0];
        REG_BOX_PAD:        box_pad        <= pwdata[7:0];
        REG_DIFF_THRESHOLD: diff_threshold <= pwdata[7:0];
        REG_MAX_DEVIATION:  max_deviation  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:    prdata = CFG_DATA_W'(frame_width);
      REG_FRAME_HEIGHT:   prdata = CFG_DATA_W'(frame_height);
      REG_WINDOW_MARGIN:  prdata = CFG_DATA_W'(window_margin);
      REG_BOX_PAD:        prdata = CFG_DATA_W'(box_pad);
      REG_DIFF_THRESHOLD: prdata = CFG_DATA_W'(diff_threshold);
      REG_MAX_DEVIATION:  prdata = CFG_DATA_W'(max_deviation);
      default:            prdata = '0;
    endcase
  end

  // The sizes in use are the register values held to the supported range.
  always_comb begin
    if (frame_width < SIZE_REG_W'(MIN_SIZE)) begin
      frame_w = W_W'(MIN_SIZE);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      frame_w = W_W'(MAX_WIDTH);
    end else begin
      frame_w = W_W'(frame_width);
    end
    if (frame_height < SIZE_REG_W'(MIN_SIZE)) begin
      frame_h = H_W'(MIN_SIZE);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      frame_h = H_W'(MAX_HEIGHT);
    end else begin
      frame_h = H_W'(frame_height);
    end
  end

  assign cfg.window_margin  = window_margin;
  assign cfg.box_pad        = box_pad;
  assign cfg.diff_threshold = diff_threshold;
  assign cfg.max_deviation  = max_deviation;

endmodule

@@ hdl/tfmb_erode.sv @@
`timescale 1ns / 1ps

module tfmb_erode
  import tfmb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT),
  localparam int W_W = COL_W + 1,
  localparam int H_W = ROW_W + 1,
  localparam int PIX_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [W_W-1:0]     frame_w,
  input  logic [H_W-1:0]     frame_h,
  input  cfg_t               cfg,
  input  logic               advance,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               frame_start,
  input  logic [PIXEL_W-1:0] prev_pixel,
  input  logic [PIXEL_W-1:0] current_pixel,
  input  logic [PIXEL_W-1:0] next_pixel,
  output logic               e_valid,
  output px_flags_t          e_flags,
  output logic [PIX_W-1:0]   e_ones,
  output logic [PIX_W-1:0]   e_sampled,
  output logic [W_W-1:0]     e_least_col,
  output logic [COL_W-1:0]   e_most_col,
  output logic [H_W-1:0]     e_least_row,
  output logic [ROW_W-1:0]   e_most_row
);

  localparam int RST_W = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
  localparam int RST_H = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;
  localparam int SC_W = ((W_W > 8) ? W_W : 8) + 1;
  localparam int SR_W = ((H_W > 8) ? H_W : 8) + 1;

  // Clearing pass of the line store
  logic             clearing;
  logic [COL_W-1:0] clear_addr;

  // Position
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_new;
  logic [ROW_W-1:0] row_new;
  logic             line_end;
  logic             frame_end;
  logic             accept;

  // Input stage
  logic               s0_valid;
  logic               s0_start;
  logic               s0_end;
  logic [COL_W-1:0]   s0_col;
  logic [ROW_W-1:0]   s0_row;
  logic [PIXEL_W-1:0] s0_prev;
  logic [PIXEL_W-1:0] s0_cur;
  logic [PIXEL_W-1:0] s0_next;

  // Line store of raw bits from the line above
  logic             row_mem [MAX_WIDTH];
  logic             mem_rd;
  logic             fwd_hit;
  logic             fwd_bit;
  logic             mem_we;
  logic [COL_W-1:0] mem_wa;
  logic             mem_wd;

  // Erosion window
  logic               left_bit;
  logic               above_left_bit;
  logic [PIXEL_W-1:0] d1;
  logic [PIXEL_W-1:0] d2;
  logic               raw;
  logic               above_raw;
  logic               col_zero;
  logic               row_zero;
  logic               motion;
  logic               step;

  // Frame totals
  logic [PIX_W-1:0] ones_total;
  logic [PIX_W-1:0] sampled_total;
  logic [W_W-1:0]   least_column;
  logic [COL_W-1:0] most_column;
  logic [H_W-1:0]   least_row;
  logic [ROW_W-1:0] most_row;
  logic [PIX_W-1:0] base_ones;
  logic [PIX_W-1:0] base_sampled;
  logic [W_W-1:0]   base_least_col;
  logic [COL_W-1:0] base_most_col;
  logic [H_W-1:0]   base_least_row;
  logic [ROW_W-1:0] base_most_row;
  logic [PIX_W-1:0] ones_upd;
  logic [PIX_W-1:0] sampled_upd;
  logic [W_W-1:0]   least_col_upd;
  logic [COL_W-1:0] most_col_upd;
  logic [H_W-1:0]   least_row_upd;
  logic [ROW_W-1:0] most_row_upd;
  logic [SC_W-1:0]  col_ext;
  logic [SC_W-1:0]  col_margin;
  logic [SR_W-1:0]  row_ext;
  logic [SR_W-1:0]  row_margin;
  logic             col_sampled;
  logic             row_sampled;
  logic             hit;

  assign in_ready = advance && !clearing;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_new   = frame_start ? '0 : column_count;
    row_new   = frame_start ? '0 : row_count;
    line_end  = ({1'b0, col_new} + W_W'(1)) >= frame_w;
    frame_end = line_end && (({1'b0, row_new} + H_W'(1)) >= frame_h);
  end

  // Raw motion of the pixel and its 2x2 erosion
  assign d1        = (s0_prev > s0_next) ? s0_prev - s0_next : s0_next - s0_prev;
  assign d2        = (s0_next > s0_cur) ? s0_next - s0_cur : s0_cur - s0_next;
  assign raw       = (d1 & d2) > cfg.diff_threshold;
  assign above_raw = fwd_hit ? fwd_bit : mem_rd;
  assign col_zero  = (s0_col == '0);
  assign row_zero  = (s0_row == '0);
  assign motion    = raw && (row_zero || above_raw) && (col_zero || left_bit)
                     && (col_zero || row_zero || above_left_bit);
  assign step      = advance && s0_valid;

  assign mem_we = clearing || step;
  assign mem_wa = clearing ? clear_addr : s0_col;
  assign mem_wd = clearing || raw;

  // Every second pixel inside the margins on both axes is sampled.
  always_comb begin
    col_ext     = SC_W'(s0_col);
    col_margin  = SC_W'(cfg.window_margin);
    row_ext     = SR_W'(s0_row);
    row_margin  = SR_W'(cfg.window_margin);
    col_sampled = (col_ext >= col_margin) && (col_ext + col_margin < SC_W'(frame_w))
                  && (s0_col[0] == cfg.window_margin[0]);
    row_sampled = (row_ext >= row_margin) && (row_ext + row_margin < SR_W'(frame_h))
                  && (s0_row[0] == cfg.window_margin[0]);
    hit         = motion && col_sampled && row_sampled;
  end

  // A frame start restarts the totals before this pixel is counted.
  always_comb begin
    base_ones      = s0_start ? '0 : ones_total;
    base_sampled   = s0_start ? '0 : sampled_total;
    base_least_col = s0_start ? frame_w : least_column;
    base_most_col  = s0_start ? '0 : most_column;
    base_least_row = s0_start ? frame_h : least_row;
    base_most_row  = s0_start ? '0 : most_row;
    ones_upd       = base_ones + PIX_W'(motion);
    sampled_upd    = base_sampled + PIX_W'(hit);
    least_col_upd  = (hit && ({1'b0, s0_col} < base_least_col)) ? {1'b0, s0_col}
                                                                 : base_least_col;
    most_col_upd   = (hit && (s0_col > base_most_col)) ? s0_col : base_most_col;
    least_row_upd  = (hit && ({1'b0, s0_row} < base_least_row)) ? {1'b0, s0_row}
                                                                 : base_least_row;
    most_row_upd   = (hit && (s0_row > base_most_row)) ? s0_row : base_most_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing       <= 1'b1;
      clear_addr     <= '0;
      column_count   <= '0;
      row_count      <= '0;
      s0_valid       <= 1'b0;
      e_valid        <= 1'b0;
      left_bit       <= 1'b1;
      above_left_bit <= 1'b1;
      ones_total     <= '0;
      sampled_total  <= '0;
      least_column   <= W_W'(RST_W);
      most_column    <= '0;
      least_row      <= H_W'(RST_H);
      most_row       <= '0;
    end else begin
      if (clearing) begin
        clear_addr <= clear_addr + COL_W'(1);
        if (clear_addr == COL_W'(MAX_WIDTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        if (frame_end) begin
          column_count <= '0;
          row_count    <= '0;
        end else if (line_end) begin
          column_count <= '0;
          row_count    <= row_new + ROW_W'(1);
        end else begin
          column_count <= col_new + COL_W'(1);
          row_count    <= row_new;
        end
      end
      if (advance) begin
        s0_valid <= accept;
        e_valid  <= s0_valid;
      end
      if (step) begin
        left_bit       <= raw;
        above_left_bit <= above_raw;
        if (s0_end) begin
          ones_total    <= '0;
          sampled_total <= '0;
          least_column  <= frame_w;
          most_column   <= '0;
          least_row     <= frame_h;
          most_row      <= '0;
        end else begin
          ones_total    <= ones_upd;
          sampled_total <= sampled_upd;
          least_column  <= least_col_upd;
          most_column   <= most_col_upd;
          least_row     <= least_row_upd;
          most_row      <= most_row_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_start <= frame_start;
      s0_end   <= frame_end;
      s0_col   <= col_new;
      s0_row   <= row_new;
      s0_prev  <= prev_pixel;
      s0_cur   <= current_pixel;
      s0_next  <= next_pixel;
      // The item ahead writes its column at this same edge; catch it here.
      fwd_hit  <= step && (s0_col == col_new);
      fwd_bit  <= raw;
    end
    if (step) begin
      e_flags.motion_bit <= motion;
      e_flags.frame_done <= s0_end;
      e_ones             <= ones_upd;
      e_sampled          <= sampled_upd;
      e_least_col        <= least_col_upd;
      e_most_col         <= most_col_upd;
      e_least_row        <= least_row_upd;
      e_most_row         <= most_row_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_rd <= row_mem[col_new];
    end
    if (mem_we) begin
      row_mem[mem_wa] <= mem_wd;
    end
  end

endmodule

@@ hdl/tfmb_gate.sv @@
`timescale 1ns / 1ps

module tfmb_gate
  import tfmb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT),
  localparam int W_W = COL_W + 1,
  localparam int H_W = ROW_W + 1,
  localparam int PIX_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [W_W-1:0]   frame_w,
  input  logic [H_W-1:0]   frame_h,
  input  cfg_t             cfg,
  input  logic             e_valid,
  input  px_flags_t        e_flags,
  input  logic [PIX_W-1:0] e_ones,
  input  logic [PIX_W-1:0] e_sampled,
  input  logic [W_W-1:0]   e_least_col,
  input  logic [COL_W-1:0] e_most_col,
  input  logic [H_W-1:0]   e_least_row,
  input  logic [ROW_W-1:0] e_most_row,
  output logic             g_valid,
  output result_t          g_result
);

  localparam int MUL_W = PIX_W + 8;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CMP_W = ((PROD_W > GATE_W) ? PROD_W : GATE_W) + 1;
  localparam int MAX_WH = (W_W > H_W) ? W_W : H_W;
  localparam int SUM_W = ((MAX_WH > 8) ? MAX_WH : 8) + 1;

  // Frame-size terms of the gate; they follow the registers every cycle.
  logic [PIX_W-1:0]  total_pixels;
  logic [MUL_W-1:0]  dev_scaled;
  logic [PROD_W-1:0] dev_sq;

  // First stage: scaled counts and padded box
  logic [PIX_W:0]    diff;
  logic              neg;
  logic [PIX_W-1:0]  mag;
  logic [MUL_W-1:0]  a_term;
  logic [MUL_W-1:0]  b_term;
  logic [SUM_W-1:0]  pad_ext;
  logic [SUM_W-1:0]  lc;
  logic [SUM_W-1:0]  mc;
  logic [SUM_W-1:0]  lr;
  logic [SUM_W-1:0]  mr;
  logic [SUM_W-1:0]  left_pad;
  logic [SUM_W-1:0]  top_pad;
  logic [SUM_W-1:0]  right_pad;
  logic [SUM_W-1:0]  bottom_pad;

  logic              g1_valid;
  px_flags_t         g1_flags;
  logic [PIX_W-1:0]  g1_sampled;
  logic [MUL_W-1:0]  g1_a;
  logic [MUL_W-1:0]  g1_b;
  logic              g1_neg;
  logic [BOX_W-1:0]  g1_left;
  logic [BOX_W-1:0]  g1_top;
  logic [BOX_W-1:0]  g1_right;
  logic [BOX_W-1:0]  g1_bottom;

  // Second stage: product and compare
  logic              g2_valid;
  px_flags_t         g2_flags;
  logic [PIX_W-1:0]  g2_sampled;
  logic [PROD_W-1:0] g2_ab;
  logic              g2_neg;
  logic [BOX_W-1:0]  g2_left;
  logic [BOX_W-1:0]  g2_top;
  logic [BOX_W-1:0]  g2_right;
  logic [BOX_W-1:0]  g2_bottom;
  logic [CMP_W-1:0]  wrapped;
  logic              pass;
  logic              found;
  logic              report;

  always_ff @(posedge clk) begin
    total_pixels <= PIX_W'(frame_w * frame_h);
    dev_scaled   <= MUL_W'(cfg.max_deviation * total_pixels);
    dev_sq       <= dev_scaled * dev_scaled;
  end

  // 255 times a count is a shift and a subtract. When more motion pixels
  // were seen than the frame holds, the second term wraps in the 64-bit
  // arithmetic of the gate, so its sign is carried on.
  always_comb begin
    diff   = {1'b0, total_pixels} - {1'b0, e_ones};
    neg    = diff[PIX_W];
    mag    = neg ? PIX_W'(~diff + 1'b1) : PIX_W'(diff);
    a_term = {e_ones, 8'd0} - MUL_W'(e_ones);
    b_term = {mag, 8'd0} - MUL_W'(mag);
  end

  always_comb begin
    pad_ext    = SUM_W'(cfg.box_pad);
    lc         = SUM_W'(e_least_col);
    mc         = SUM_W'(e_most_col);
    lr         = SUM_W'(e_least_row);
    mr         = SUM_W'(e_most_row);
    left_pad   = (lc > pad_ext) ? lc - pad_ext : lc;
    top_pad    = (lr > pad_ext) ? lr - pad_ext : lr;
    right_pad  = (mc + pad_ext + SUM_W'(1) < SUM_W'(frame_w)) ? mc + pad_ext : mc;
    bottom_pad = (mr + pad_ext + SUM_W'(1) < SUM_W'(frame_h)) ? mr + pad_ext : mr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_valid <= 1'b0;
      g2_valid <= 1'b0;
    end else if (advance) begin
      g1_valid <= e_valid;
      g2_valid <= g1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      g1_flags   <= e_flags;
      g1_sampled <= e_sampled;
      g1_a       <= a_term;
      g1_b       <= b_term;
      g1_neg     <= neg;
      g1_left    <= BOX_W'(left_pad);
      g1_top     <= BOX_W'(top_pad);
      g1_right   <= BOX_W'(right_pad);
      g1_bottom  <= BOX_W'(bottom_pad);
      g2_flags   <= g1_flags;
      g2_sampled <= g1_sampled;
      g2_ab      <= g1_a * g1_b;
      g2_neg     <= g1_neg;
      g2_left    <= g1_left;
      g2_top     <= g1_top;
      g2_right   <= g1_right;
      g2_bottom  <= g1_bottom;
    end
  end

  always_comb begin
    wrapped = (CMP_W'(1) << GATE_W) - CMP_W'(g2_ab);
    if (!g2_neg) begin
      pass = CMP_W'(g2_ab) < CMP_W'(dev_sq);
    end else if (g2_ab == '0) begin
      pass = (dev_sq != '0);
    end else begin
      pass = wrapped < CMP_W'(dev_sq);
    end
    found  = pass && (g2_sampled != '0);
    report = g2_flags.frame_done && found;

    g_result.motion_bit   = g2_flags.motion_bit;
    g_result.frame_done   = g2_flags.frame_done;
    g_result.change_count = report ? COUNT_W'(g2_sampled) : '0;
    g_result.box_left     = report ? g2_left : '0;
    g_result.box_top      = report ? g2_top : '0;
    g_result.box_right    = report ? g2_right : '0;
    g_result.box_bottom   = report ? g2_bottom : '0;
    g_result.motion_found = report;
  end

  assign g_valid = g2_valid;

endmodule

@@ tb/sv/tb_three_frame_motion_box.sv @@
`timescale 1ns / 1ps

import tfmb_pkg::*;

class motion_scoreboard;
  bit [10:0] width_reg, height_reg;
  bit [7:0] margin, pad, threshold, deviation;

  bit row_above [0:1023];
  bit left_raw, above_left_raw;
  int unsigned col_pos, row_pos;
  int unsigned ones_cnt, sampled_cnt;
  int unsigned min_col, max_col, min_row, max_row;

  result_t expected_q[$];
  int errors;
  int checked;

  function new();
    width_reg = RST_FRAME_WIDTH;
    height_reg = RST_FRAME_HEIGHT;
    margin = RST_WINDOW_MARGIN;
    pad = RST_BOX_PAD;
    threshold = RST_DIFF_THRESHOLD;
    deviation = RST_MAX_DEVIATION;
    foreach (row_above[i]) row_above[i] = 1'b1;
    left_raw = 1'b1;
    above_left_raw = 1'b1;
    col_pos = 0;
    row_pos = 0;
    restart_totals(RST_FRAME_WIDTH, RST_FRAME_HEIGHT);
    errors = 0;
    checked = 0;
  endfunction

  function void restart_totals(int unsigned w, int unsigned h);
    ones_cnt = 0;
    sampled_cnt = 0;
    min_col = w;
    max_col = 0;
    min_row = h;
    max_row = 0;
  endfunction

  function void set_register(reg_index_t idx, logic [31:0] value);
    case (idx)
      REG_FRAME_WIDTH: width_reg = value[10:0];
      REG_FRAME_HEIGHT: height_reg = value[10:0];
      REG_WINDOW_MARGIN: margin = value[7:0];
      REG_BOX_PAD: pad = value[7:0];
      REG_DIFF_THRESHOLD: threshold = value[7:0];
      REG_MAX_DEVIATION: deviation = value[7:0];
      default: ;
    endcase
  endfunction

  // Only every second position inside the margins counts towards the box.
  function bit on_grid(int unsigned pos, int unsigned size);
    return pos >= margin && pos + margin < size && ((pos - margin) % 2 == 0);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_item(logic fs, logic [7:0] p, logic [7:0] c, logic [7:0] n);
    int unsigned w, h, col, row;
    int unsigned l, t, r, bo;
    bit [7:0] d1, d2;
    bit raw, above, left, above_left, eroded;
    bit line_end, frame_end;
    bit [63:0] total, a, b, d;
    result_t res;
    w = (width_reg < MIN_SIZE) ? MIN_SIZE : ((width_reg > 1024) ? 1024 : width_reg);
    h = (height_reg < MIN_SIZE) ? MIN_SIZE : ((height_reg > 1024) ? 1024 : height_reg);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
      restart_totals(w, h);
    end
    col = col_pos;
    row = row_pos;

    d1 = (p > n) ? p - n : n - p;
    d2 = (n > c) ? n - c : c - n;
    raw = (d1 & d2) > threshold;

    // Erosion over the pixel, its left neighbour, above and above-left;
    // anything outside the image counts as set.
    above = row_above[col % 1024];
    left = left_raw;
    above_left = above_left_raw;
    if (col == 0) begin
      left = 1'b1;
      above_left = 1'b1;
    end
    if (row == 0) begin
      above = 1'b1;
      above_left = 1'b1;
    end
    eroded = raw & left & above & above_left;

    above_left_raw = row_above[col % 1024];
    row_above[col % 1024] = raw;
    left_raw = raw;

    ones_cnt += eroded;
    if (eroded && on_grid(col, w) && on_grid(row, h)) begin
      sampled_cnt++;
      if (col < min_col) min_col = col;
      if (col > max_col) max_col = col;
      if (row < min_row) min_row = row;
      if (row > max_row) max_row = row;
    end

    line_end = col + 1 >= w;
    frame_end = line_end && (row + 1 >= h);

    res = '0;
    res.motion_bit = eroded;
    if (frame_end) begin
      total = 64'(w) * 64'(h);
      a = 64'd255 * ones_cnt;
      b = 64'd255 * (total - ones_cnt);
      d = deviation * total;
      res.frame_done = 1'b1;
      if (a * b < d * d && sampled_cnt != 0) begin
        l = min_col;
        t = min_row;
        r = max_col;
        bo = max_row;
        if (l > pad) l -= pad;
        if (t > pad) t -= pad;
        if (r + pad + 1 < w) r += pad;
        if (bo + pad + 1 < h) bo += pad;
        res.change_count = sampled_cnt[COUNT_W-1:0];
        res.box_left = l[BOX_W-1:0];
        res.box_top = t[BOX_W-1:0];
        res.box_right = r[BOX_W-1:0];
        res.box_bottom = bo[BOX_W-1:0];
        res.motion_found = 1'b1;
      end
      col_pos = 0;
      row_pos = 0;
      restart_totals(w, h);
    end else if (line_end) begin
      col_pos = 0;
      row_pos = row + 1;
    end else begin
      col_pos = col + 1;
    end
    expected_q.push_back(res);
  endfunction

  task report(string field, longint unsigned got, longint unsigned want);
    $display("mismatch at result %0d, %s: got %0d, expected %0d", checked, field, got, want);
    errors++;
  endtask

  task check_result(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      report("result with no item waiting", 0, 0);
      return;
    end
    want = expected_q.pop_front();
    if (got.motion_bit !== want.motion_bit)
      report("motion_bit", got.motion_bit, want.motion_bit);
    if (got.frame_done !== want.frame_done)
      report("frame_done", got.frame_done, want.frame_done);
    if (got.change_count !== want.change_count)
      report("change_count", got.change_count, want.change_count);
    if (got.box_left !== want.box_left)
      report("box_left", got.box_left, want.box_left);
    if (got.box_top !== want.box_top)
      report("box_top", got.box_top, want.box_top);
    if (got.box_right !== want.box_right)
      report("box_right", got.box_right, want.box_right);
    if (got.box_bottom !== want.box_bottom)
      report("box_bottom", got.box_bottom, want.box_bottom);
    if (got.motion_found !== want.motion_found)
      report("motion_found", got.motion_found, want.motion_found);
    checked++;
  endtask
endclass

module tb_three_frame_motion_box;
  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic frame_start;
  logic [PIXEL_W-1:0] prev_pixel;
  logic [PIXEL_W-1:0] current_pixel;
  logic [PIXEL_W-1:0] next_pixel;
  logic out_valid;
  logic out_ready;
  logic motion_bit;
  logic frame_done;
  logic [COUNT_W-1:0] change_count;
  logic [BOX_W-1:0] box_left;
  logic [BOX_W-1:0] box_top;
  logic [BOX_W-1:0] box_right;
  logic [BOX_W-1:0] box_bottom;
  logic motion_found;

  motion_scoreboard sb;

  bit quiet = 1'b0;
  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  int hold_left = 0;

  three_frame_motion_box u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  task apb_write(input reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = CFG_ADDR_W'(4 * idx);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task set_config(input logic [31:0] width_val, input logic [31:0] height_val,
                  input logic [31:0] margin_val, input logic [31:0] pad_val,
                  input logic [31:0] thr_val, input logic [31:0] dev_val);
    apb_write(REG_FRAME_WIDTH, width_val);
    apb_write(REG_FRAME_HEIGHT, height_val);
    apb_write(REG_WINDOW_MARGIN, margin_val);
    apb_write(REG_BOX_PAD, pad_val);
    apb_write(REG_DIFF_THRESHOLD, thr_val);
    apb_write(REG_MAX_DEVIATION, dev_val);
  endtask

  // Stops offering items and waits until every expected result has come out.
  task drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task send_item(input logic fs, input logic [7:0] p, input logic [7:0] c,
                 input logic [7:0] n);
    if (tx_gaps && !quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    frame_start = fs;
    prev_pixel = p;
    current_pixel = c;
    next_pixel = n;
    do @(posedge clk); while (!in_ready);
    sb.note_item(fs, p, c, n);
  endtask

  // Sends count pixels in raster order over a frame of fw by fh, in most frames
  // with a dense patch of strong three-way differences somewhere in it.
  task send_frame(input int fw, input int fh, input int count, input bit mark_start,
                  input bit noisy);
    int k, col, row, bl, br, bt, bb, r;
    bit hit, fs;
    logic [7:0] p, c, n;
    bl = $urandom_range(0, fw - 1);
    br = $urandom_range(bl, fw - 1);
    bt = $urandom_range(0, fh - 1);
    bb = $urandom_range(bt, fh - 1);
    if ($urandom_range(0, 3) == 0) bl = fw;
    for (k = 0; k < count; k++) begin
      col = k % fw;
      row = (k / fw) % fh;
      hit = col >= bl && col <= br && row >= bt && row <= bb;
      r = $urandom_range(0, 9);
      if (hit && r < 8) begin
        p = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
        n = $urandom_range(192, 255);
        if ($urandom_range(0, 1)) begin
          p = ~p;
          c = ~c;
          n = ~n;
        end
      end else if (r == 9 || (!hit && r == 8)) begin
        p = $urandom;
        c = $urandom;
        n = $urandom;
      end else begin
        p = $urandom;
        c = p ^ 8'($urandom_range(0, 7));
        n = p ^ 8'($urandom_range(0, 7));
      end
      fs = (k == 0 && mark_start) || (noisy && $urandom_range(0, 399) == 0);
      send_item(fs, p, c, n);
    end
  endtask

  // Result side: random back-pressure, plus a long hold-off on request.
  initial begin
    int stall_left;
    result_t got;
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (rx_stalls && !quiet && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready = 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.motion_bit = motion_bit;
        got.frame_done = frame_done;
        got.change_count = change_count;
        got.box_left = box_left;
        got.box_top = box_top;
        got.box_right = box_right;
        got.box_bottom = box_bottom;
        got.motion_found = motion_found;
        sb.check_result(got);
      end
    end
  end

  initial begin
    int random_items, wr, hr, fw, fh, nf, kind, cnt, mg, pd, th, dv;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    frame_start = 1'b0;
    prev_pixel = '0;
    current_pixel = '0;
    next_pixel = '0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Field extremes and the threshold boundary under the reset settings,
    // including a frame start in the middle of a line.
    send_item(1'b1, 8'd0, 8'd0, 8'd0);
    send_item(1'b0, 8'd255, 8'd255, 8'd255);
    send_item(1'b0, 8'd0, 8'd0, 8'd255);
    send_item(1'b0, 8'd255, 8'd255, 8'd0);
    send_item(1'b1, 8'd0, 8'd255, 8'd255);
    send_item(1'b0, 8'd255, 8'd0, 8'd0);
    send_item(1'b0, 8'd0, 8'd0, 8'd35);
    send_item(1'b0, 8'd0, 8'd0, 8'd36);
    send_item(1'b0, 8'd0, 8'd0, 8'd36);
    send_item(1'b0, 8'd170, 8'd0, 8'd85);
    send_item(1'b0, 8'd128, 8'd0, 8'd127);
    repeat (13) send_item(1'b0, $urandom, $urandom, $urandom);

    // Shrinking the width leaves the column past the new line end, and the
    // frame then runs to its end with no frame start.
    drain();
    set_config(16, 16, 0, 0, 35, 255);
    send_frame(16, 16, 241, 1'b0, 1'b0);
    send_frame(16, 16, 256, 1'b1, 1'b0);

    // Sizes below range, margins too wide to sample, a gate that never passes.
    drain();
    set_config(0, 5, 255, 255, 0, 0);
    send_frame(16, 16, 256, 1'b1, 1'b0);

    // Widest line with the result side held off, so the input backs up.
    drain();
    tx_gaps = 1'b0;
    hold_left = 120;
    set_config(2047, 2047, 10, 10, 35, 20);
    send_frame(1024, 1024, 1040, 1'b1, 1'b0);

    // Tallest frame, cut short by lowering the height past the current row.
    drain();
    tx_gaps = 1'b1;
    set_config(16, 2047, 2, 1, 35, 90);
    send_frame(16, 1024, 288, 1'b1, 1'b0);
    drain();
    apb_write(REG_FRAME_HEIGHT, 16);
    send_frame(16, 16, 16, 1'b0, 1'b0);

    drain();
    set_config(24, 16, 1, 2, 255, 128);
    send_frame(24, 16, 384, 1'b1, 1'b0);

    random_items = 0;
    while (random_items < 1250) begin
      drain();
      quiet = random_items >= 1000;
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;
      wr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(16, 24);
      hr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(16, 20);
      case ($urandom_range(0, 7))
        0: mg = 0;
        1: mg = 255;
        2: mg = $urandom_range(6, 10);
        default: mg = $urandom_range(0, 4);
      endcase
      pd = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 255);
      th = $urandom_range(0, 1) ? $urandom_range(20, 140) : $urandom_range(0, 255);
      dv = $urandom_range(0, 255);
      set_config(wr, hr, mg, pd, th, dv);
      fw = (wr < MIN_SIZE) ? MIN_SIZE : wr;
      fh = (hr < MIN_SIZE) ? MIN_SIZE : hr;
      nf = $urandom_range(1, 2);
      repeat (nf) begin
        kind = $urandom_range(0, 5);
        cnt = (kind == 1) ? $urandom_range(1, fw * fh - 1) : fw * fh;
        send_frame(fw, fh, cnt, kind != 0, 1'b1);
        random_items += cnt;
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

@@ files.f @@
hdl/tfmb_pkg.sv
hdl/tfmb_cfg.sv
hdl/tfmb_erode.sv
hdl/tfmb_gate.sv
hdl/three_frame_motion_box.sv
tb/sv/tb_three_frame_motion_box.sv
